FILE: rtl/apwg_pkg.sv
// ----------------------------------------------------------------------------
// apwg_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package apwg_pkg;

  localparam int CoordWidth  = 16;
  localparam int CordicSteps = 16;
  localparam int IterWidth   = $clog2(CordicSteps + 1);
  // cordic vector width: coordinate difference scaled by 2^20 plus growth
  localparam int VecWidth    = CoordWidth + 1 + 20 + 2;
  localparam int AngWidth    = 26;
  localparam int HeadWidth   = 13;
  localparam int HeadLimit   = 2880;

  localparam logic [1:0] CmdNone = 2'd0;
  localparam logic [1:0] CmdMove = 2'd1;
  localparam logic [1:0] CmdStop = 2'd2;

  localparam logic [2:0] RegTargetX = 3'd0;
  localparam logic [2:0] RegTargetY = 3'd1;
  localparam logic [2:0] RegStartX  = 3'd2;
  localparam logic [2:0] RegStartY  = 3'd3;
  localparam logic [2:0] RegSpeed   = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StCordic,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture item and decide
    logic step;     // one cordic iteration
    logic finish;   // round heading into result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_cordic;
  } status_t;

  function automatic logic signed [AngWidth-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngWidth-1:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234378;
      5'd5:  r = 26'sd117303;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/apwg_ctrl.sv
// ----------------------------------------------------------------------------
// apwg_ctrl
// sequencer for one request: decide, iterate cordic, present result
// ----------------------------------------------------------------------------
module apwg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  apwg_pkg::status_t status_i,
  output apwg_pkg::cmd_t   cmd_o
);
  import apwg_pkg::*;

  state_e state_q, state_d;
  logic [IterWidth-1:0] iter_q, iter_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          state_d    = StCordic;
        end
      end
      StCordic: begin
        if (!status_i.need_cordic) begin
          state_d = StOut;
        end else if (iter_q == IterWidth'(CordicSteps)) begin
          cmd_o.finish = 1'b1;
          state_d      = StOut;
        end else begin
          cmd_o.step = 1'b1;
          iter_d     = iter_q + 1'b1;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> iter_q < IterWidth'(CordicSteps))
    else $error("cordic step past last iteration");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepting while result pending");

endmodule

FILE: rtl/apwg_datapath.sv
// ----------------------------------------------------------------------------
// apwg_datapath
// guidance state, distance compares and shared cordic unit
// ----------------------------------------------------------------------------
module apwg_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  apwg_pkg::cmd_t                  cmd_i,
  output apwg_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            operation_i,
  input  logic signed [apwg_pkg::CoordWidth-1:0] pos_x_i,
  input  logic signed [apwg_pkg::CoordWidth-1:0] pos_y_i,
  input  logic signed [apwg_pkg::CoordWidth-1:0] detour_x_i,
  input  logic signed [apwg_pkg::CoordWidth-1:0] detour_y_i,
  output logic [1:0]                      command_o,
  output logic [15:0]                     speed_o,
  output logic signed [apwg_pkg::HeadWidth-1:0] heading_o,
  output logic                            task_done_o,
  output logic                            avoiding_o
);
  import apwg_pkg::*;

  localparam int DW = CoordWidth + 1;

  logic signed [CoordWidth-1:0] tgt_x_q, tgt_y_q, org_x_q, org_y_q, det_x_q, det_y_q;
  logic [15:0] speed_cfg_q;
  logic avoid_q, prefer_x_q, x_arr_q, y_arr_q, fin_q;
  logic [1:0] cmd_q;
  logic signed [HeadWidth-1:0] head_q;
  logic need_q;
  logic signed [VecWidth-1:0] cx_q, cy_q;
  logic signed [AngWidth-1:0] cz_q;
  logic [4:0] it_q;

  // distance compare with saturation at 64
  function automatic logic near(input logic signed [DW-1:0] dx,
                                input logic signed [DW-1:0] dy,
                                input logic [12:0] lim);
    logic [DW-1:0] ax, ay;
    logic [6:0] sx, sy;
    logic [13:0] s;
    ax = dx[DW-1] ? -dx : dx;
    ay = dy[DW-1] ? -dy : dy;
    sx = (ax > DW'(64)) ? 7'd64 : ax[6:0];
    sy = (ay > DW'(64)) ? 7'd64 : ay[6:0];
    s  = 14'(sx * sx) + 14'(sy * sy);
    return s < 14'(lim);
  endfunction

  // differences for each case
  logic signed [DW-1:0] px, py, tdx, tdy, ddx, ddy, oxd, oyd;
  assign px  = DW'(pos_x_i);
  assign py  = DW'(pos_y_i);
  assign tdx = DW'(tgt_x_q) - px;
  assign tdy = DW'(tgt_y_q) - py;
  assign ddx = DW'(det_x_q) - px;
  assign ddy = DW'(det_y_q) - py;
  assign oxd = DW'(org_x_q) - px;
  assign oyd = DW'(org_y_q) - py;

  logic t_near, t_close, d_near, xl_near, yl_near;
  assign t_near  = near(tdx, tdy, 13'd100);
  assign t_close = near(tdx, tdy, 13'd2500);
  assign d_near  = near(ddx, ddy, 13'd100);
  assign xl_near = near(tdx, oyd, 13'd100);
  assign yl_near = near(oxd, tdy, 13'd100);

  // vector selection
  logic signed [DW-1:0] vx, vy;
  always_comb begin
    vx = tdx;
    vy = tdy;
    if (avoid_q) begin
      vx = ddx; vy = ddy;
    end else if (!t_close && prefer_x_q) begin
      vy = oyd;
    end else if (!t_close) begin
      vx = oxd;
    end
  end

  // zero vector keeps heading zero and skips the cordic
  logic vzero;
  assign vzero = (vx == '0) && (vy == '0);

  // cordic iteration
  logic signed [VecWidth-1:0] sx_w, sy_w;
  assign sx_w = cx_q >>> it_q;
  assign sy_w = cy_q >>> it_q;

  // rounded heading
  logic [AngWidth-1:0] zabs;
  logic [AngWidth-1:0] hmag;
  assign zabs = cz_q[AngWidth-1] ? AngWidth'(-cz_q) : AngWidth'(cz_q);
  assign hmag = (zabs + AngWidth'(2048)) >> 12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q <= '0; tgt_y_q <= '0; org_x_q <= '0; org_y_q <= '0;
      det_x_q <= '0; det_y_q <= '0; speed_cfg_q <= '0;
      avoid_q <= 1'b0; prefer_x_q <= 1'b0; x_arr_q <= 1'b0;
      y_arr_q <= 1'b0; fin_q <= 1'b0; need_q <= 1'b0;
      cmd_q <= CmdNone; head_q <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTargetX: tgt_x_q <= cfg_data_i;
          RegTargetY: tgt_y_q <= cfg_data_i;
          RegStartX:  org_x_q <= cfg_data_i;
          RegStartY:  org_y_q <= cfg_data_i;
          RegSpeed:   speed_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      // per-request decision
      if (cmd_i.load) begin
        cmd_q  <= CmdNone;
        head_q <= '0;
        need_q <= 1'b0;
        if (!fin_q) begin
          if (operation_i) begin
            det_x_q <= detour_x_i;
            det_y_q <= detour_y_i;
            avoid_q <= 1'b1;
          end else if (avoid_q) begin
            if (d_near) begin
              org_x_q <= pos_x_i; org_y_q <= pos_y_i;
              x_arr_q <= 1'b0; y_arr_q <= 1'b0; avoid_q <= 1'b0;
            end else begin
              cmd_q <= CmdMove; need_q <= !vzero;
            end
          end else if (t_near) begin
            cmd_q <= CmdStop; fin_q <= 1'b1;
          end else if (t_close) begin
            cmd_q <= CmdMove; need_q <= !vzero;
          end else if (prefer_x_q) begin
            cmd_q <= CmdMove; need_q <= !vzero;
            if (xl_near) begin
              org_x_q <= pos_x_i; x_arr_q <= 1'b1;
              if (!y_arr_q) prefer_x_q <= 1'b0;
              else fin_q <= 1'b1;
            end
          end else begin
            cmd_q <= CmdMove; need_q <= !vzero;
            if (yl_near) begin
              org_y_q <= pos_y_i; y_arr_q <= 1'b1;
              if (!x_arr_q) prefer_x_q <= 1'b1;
              else fin_q <= 1'b1;
            end
          end
        end
      end
      if (cmd_i.finish) begin
        if (hmag > AngWidth'(HeadLimit)) head_q <= cz_q[AngWidth-1] ?
            -HeadWidth'(HeadLimit) : HeadWidth'(HeadLimit);
        else head_q <= cz_q[AngWidth-1] ? -HeadWidth'(hmag) : HeadWidth'(hmag);
      end
    end
  end

  // cordic registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= '0;
      if (vzero) begin
        cx_q <= '0; cy_q <= '0; cz_q <= '0;
      end else if (vx[DW-1]) begin
        if (!vy[DW-1]) begin
          cx_q <= VecWidth'(vy) <<< 20; cy_q <= -(VecWidth'(vx) <<< 20);
          cz_q <= AngWidth'(90 * 65536);
        end else begin
          cx_q <= -(VecWidth'(vy) <<< 20); cy_q <= VecWidth'(vx) <<< 20;
          cz_q <= -AngWidth'(90 * 65536);
        end
      end else begin
        cx_q <= VecWidth'(vx) <<< 20; cy_q <= VecWidth'(vy) <<< 20; cz_q <= '0;
      end
    end else if (cmd_i.step) begin
      it_q <= it_q + 1'b1;
      if (!cy_q[VecWidth-1]) begin
        cx_q <= cx_q + sy_w; cy_q <= cy_q - sx_w; cz_q <= cz_q + atan_entry(it_q);
      end else begin
        cx_q <= cx_q - sy_w; cy_q <= cy_q + sx_w; cz_q <= cz_q - atan_entry(it_q);
      end
    end
  end

  assign status_o.need_cordic = need_q;
  assign command_o   = cmd_q;
  assign speed_o     = (cmd_q == CmdMove) ? speed_cfg_q : 16'd0;
  assign heading_o   = head_q;
  assign task_done_o = fin_q;
  assign avoiding_o  = avoid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && fin_q |=> cmd_q == CmdNone)
    else $error("command issued after finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q |-> cmd_q == CmdMove)
    else $error("cordic without move");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CmdStop |-> fin_q)
    else $error("stop without finish");

endmodule

FILE: rtl/axis_priority_waypoint_guidance_unit.sv
// a request is decided when it is accepted; an item with no heading is then presented,
// one with a heading first runs the cordic iterations and the rounding
// a request is taken only after the previous result is delivered
// reset clears the guidance state, configuration registers and origin, but not the cordic registers, to zero
// ----------------------------------------------------------------------------
// axis_priority_waypoint_guidance_unit
// waypoint guidance with axis priority, detour mode and cordic heading
// ----------------------------------------------------------------------------
module axis_priority_waypoint_guidance_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // pos_x, pos_y, detour_x, detour_y
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // command, speed, heading, task_done, avoiding
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import apwg_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [1:0] command;
  logic [15:0] speed;
  logic signed [HeadWidth-1:0] heading;
  logic done, avoiding;

  assign cfg_ready_o = 1'b1;

  apwg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd)
  );

  apwg_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .operation_i(s_axis_tuser),
    .pos_x_i(s_axis_tdata[15:0]), .pos_y_i(s_axis_tdata[31:16]),
    .detour_x_i(s_axis_tdata[47:32]), .detour_y_i(s_axis_tdata[63:48]),
    .command_o(command), .speed_o(speed), .heading_o(heading),
    .task_done_o(done), .avoiding_o(avoiding)
  );

  assign m_axis_tdata = {7'd0, avoiding, done, heading, speed, command};

endmodule

FILE: dv/axis_priority_waypoint_guidance_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_priority_waypoint_guidance_unit_tb
// self-checking bench: directed table then steered random position updates,
// every result compared against an in-bench guidance predictor
// ----------------------------------------------------------------------------
module axis_priority_waypoint_guidance_unit_tb;
  import apwg_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int NumRandom = 1700;

  typedef struct {
    bit              avoid_req;
    logic [15:0]     px, py, detx, dety;
  } request_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        speed;
    logic signed [12:0] heading;
    logic               done;
    logic               avoiding;
  } guide_result_t;

  typedef struct {
    longint tgt_x, tgt_y, speed;
    bit     avoid_on, prefer_x, x_arr, y_arr, done;
    longint det_x, det_y, org_x, org_y;
  } guide_state_t;

  // directed row: expected typed in only where chk is set
  typedef struct {
    bit          op;
    int          px, py, detx, dety;
    bit          chk;
    logic [1:0]  cmd;
  } row_t;

  localparam longint ArcTab [16] = '{
    2949120, 1740967, 919879, 466945, 234378, 117303, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // pos_x, pos_y, detour_x, detour_y
  logic        s_axis_tuser = 1'b0; // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // command, speed, heading, task_done, avoiding
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  guide_state_t  guide;
  guide_result_t expected_q[$];
  int            fail_count = 0;
  int            idle_cycles = 0;
  bit            long_hold_req = 1'b0;
  bit            final_phase = 1'b0;

  axis_priority_waypoint_guidance_unit DUT (.*);

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic bit within_sq(longint dx, longint dy, longint lim);
    longint ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax > 64) ax = 64;
    if (ay > 64) ay = 64;
    return ax * ax + ay * ay < lim;
  endfunction

  // vectoring cordic, degrees with 16 fraction bits, rounded to 1/16 degree
  function automatic logic signed [12:0] bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys, h;
    if (dx == 0 && dy == 0) return '0;
    x = dx * (64'sd1 << 20);
    y = dy * (64'sd1 << 20);
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ArcTab[i];
      end else begin
        x -= ys; y += xs; z -= ArcTab[i];
      end
    end
    if (z >= 0) h = (z + 2048) >>> 12;
    else h = -((-z + 2048) >>> 12);
    if (h > HeadLimit) h = HeadLimit;
    if (h < -HeadLimit) h = -HeadLimit;
    return h[12:0];
  endfunction

  // one guidance decision, advances the given state
  function automatic guide_result_t guide_step(inout guide_state_t g, input request_t rq);
    guide_result_t r;
    longint px, py, dx, dy;
    r.cmd = CmdNone;
    r.heading = '0;
    px = sx16(rq.px);
    py = sx16(rq.py);
    if (!g.done) begin
      if (rq.avoid_req) begin
        g.det_x = sx16(rq.detx);
        g.det_y = sx16(rq.dety);
        g.avoid_on = 1'b1;
      end else if (g.avoid_on) begin
        dx = g.det_x - px;
        dy = g.det_y - py;
        if (within_sq(dx, dy, 100)) begin
          g.org_x = px; g.org_y = py;
          g.x_arr = 1'b0; g.y_arr = 1'b0; g.avoid_on = 1'b0;
        end else begin
          r.cmd = CmdMove; r.heading = bearing(dx, dy);
        end
      end else begin
        dx = g.tgt_x - px;
        dy = g.tgt_y - py;
        if (within_sq(dx, dy, 100)) begin
          r.cmd = CmdStop; g.done = 1'b1;
        end else if (within_sq(dx, dy, 2500)) begin
          r.cmd = CmdMove; r.heading = bearing(dx, dy);
        end else if (g.prefer_x) begin
          dy = g.org_y - py;
          r.cmd = CmdMove; r.heading = bearing(dx, dy);
          if (within_sq(dx, dy, 100)) begin
            g.org_x = px; g.x_arr = 1'b1;
            if (!g.y_arr) g.prefer_x = 1'b0;
            else g.done = 1'b1;
          end
        end else begin
          dx = g.org_x - px;
          r.cmd = CmdMove; r.heading = bearing(dx, dy);
          if (within_sq(dx, dy, 100)) begin
            g.org_y = py; g.y_arr = 1'b1;
            if (!g.x_arr) g.prefer_x = 1'b1;
            else g.done = 1'b1;
          end
        end
      end
    end
    r.speed = r.cmd == CmdMove ? g.speed[15:0] : 16'd0;
    r.done = g.done;
    r.avoiding = g.avoid_on;
    return r;
  endfunction

  task automatic cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    cycles(25);
  endtask

  // one register write; the caller drops valid after the last one
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegTargetX: guide.tgt_x = sx16(val);
      RegTargetY: guide.tgt_y = sx16(val);
      RegStartX:  guide.org_x = sx16(val);
      RegStartY:  guide.org_y = sx16(val);
      RegSpeed:   guide.speed = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(int tx, int ty, int ox, int oy, int spd);
    write_reg(RegTargetX, tx[15:0]);
    write_reg(RegTargetY, ty[15:0]);
    write_reg(RegStartX, ox[15:0]);
    write_reg(RegStartY, oy[15:0]);
    write_reg(RegSpeed, spd[15:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // send one request; the expectation is queued at acceptance
  task automatic send(request_t rq, output guide_result_t res);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rq.avoid_req;
    s_axis_tdata <= {rq.dety, rq.detx, rq.py, rq.px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = guide_step(guide, rq);
    expected_q.push_back(res);
    if ($urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 19) == 0) cycles($urandom_range(20, 60));
      else cycles($urandom_range(1, 3));
    end
  endtask

  function automatic int near(longint c, int span);
    return int'(c) + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // steered random request that follows the current guidance phase
  function automatic request_t pick_request();
    request_t rq;
    guide_state_t probe;
    guide_result_t r;
    int sel, x, y;
    sel = $urandom_range(0, 99);
    rq.avoid_req = 1'b0;
    rq.detx = 16'($urandom);
    rq.dety = 16'($urandom);
    x = $urandom;
    y = $urandom;
    if (sel < 8) begin
      rq.avoid_req = 1'b1;
      if ($urandom_range(0, 1)) begin
        rq.detx = 16'(near(guide.tgt_x, 300));
        rq.dety = 16'(near(guide.tgt_y, 300));
      end
    end else if (guide.avoid_on && sel < 70) begin
      x = near(guide.det_x, 14);
      y = near(guide.det_y, 14);
    end else if (sel < 30) begin
      x = near(guide.tgt_x, 70);
      y = near(guide.tgt_y, 70);
    end else if (sel < 85) begin
      if (guide.prefer_x) begin
        y = near(guide.org_y, 9);
        x = $urandom_range(0, 1) ? near(guide.tgt_x, 14) : near(guide.tgt_x, 1500);
      end else begin
        x = near(guide.org_x, 9);
        y = $urandom_range(0, 1) ? near(guide.tgt_y, 14) : near(guide.tgt_y, 1500);
      end
    end
    rq.px = x[15:0];
    rq.py = y[15:0];
    // finishing is permanent, so keep it for the final phase
    probe = guide;
    r = guide_step(probe, rq);
    if (r.done && !final_phase) rq.avoid_req = 1'b1;
    return rq;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    guide_result_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[1:0] !== e.cmd) begin
          $error("command exp %0d got %0d", e.cmd, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[17:2] !== e.speed) begin
          $error("speed exp %0d got %0d", e.speed, m_axis_tdata[17:2]);
          fail_count++;
        end
        if (m_axis_tdata[30:18] !== e.heading) begin
          $error("heading exp %0d got %0d", e.heading, $signed(m_axis_tdata[30:18]));
          fail_count++;
        end
        if (m_axis_tdata[31] !== e.done) begin
          $error("task_done exp %0d got %0d", e.done, m_axis_tdata[31]);
          fail_count++;
        end
        if (m_axis_tdata[32] !== e.avoiding) begin
          $error("avoiding exp %0d got %0d", e.avoiding, m_axis_tdata[32]);
          fail_count++;
        end
      end
    end
  end

  // result back-pressure, with one long hold on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        cycles(400);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(0, 15) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 3);
        cycles(gap - 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on accepted transfers
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[axis_priority_waypoint_guidance_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    row_t          rows[$];
    request_t      rq;
    guide_result_t res;
    int            ox, oy;
    guide = '{default: 0};
    cycles(5);
    rst_ni <= 1'b1;
    cycles(2);
    load_regs(1000, 2000, 0, 0, 65535);

    rows = '{
      '{0, 0, 0, 0, 0, 0, CmdNone},
      '{0, -32768, -32768, 0, 0, 0, CmdNone},
      '{0, 32767, 32767, 0, 0, 0, CmdNone},
      '{1, 0, 0, 100, 100, 1, CmdNone},            // avoid request
      '{1, 0, 0, -32768, 32767, 1, CmdNone},       // re-latch while avoiding
      '{0, 5000, -5000, 0, 0, 0, CmdNone},         // steer to detour
      '{0, -32768, 32767, 0, 0, 1, CmdNone},       // detour reached
      '{1, 0, 0, 5, 5, 1, CmdNone},
      '{0, 0, 0, 0, 0, 1, CmdNone},                // detour reached, origin 0,0
      '{0, 3, 400, 0, 0, 0, CmdNone},              // y leg in flight
      '{0, 0, 1995, 0, 0, 0, CmdNone},             // y leg arrives, priority swaps
      '{0, 500, 2000, 0, 0, 0, CmdNone},           // x leg
      '{0, 2000, 2001, 0, 0, 0, CmdNone},          // x leg from the far side
      '{0, 960, 2000, 0, 0, 0, CmdNone},           // straight at target
      '{0, 1000, 2100, 0, 0, 0, CmdNone},
      '{0, 1000, 1951, 0, 0, 0, CmdNone}
    };
    foreach (rows[i]) begin
      rq.avoid_req = rows[i].op;
      rq.px = rows[i].px[15:0];
      rq.py = rows[i].py[15:0];
      rq.detx = rows[i].detx[15:0];
      rq.dety = rows[i].dety[15:0];
      send(rq, res);
      if (rows[i].chk && (res.cmd !== rows[i].cmd || res.speed !== 16'd0)) begin
        $error("row %0d: command exp %0d got %0d", i, rows[i].cmd, res.cmd);
        fail_count++;
      end
    end

    // random phases under several register settings
    for (int ph = 0; ph < 8; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      case (ph)
        0: load_regs(32767, 32767, -32768, -32768, 0);
        1: load_regs(-32768, -32768, 32767, 32767, 65535);
        default: begin
          ox = $signed($urandom_range(0, 40000)) - 20000;
          oy = $signed($urandom_range(0, 40000)) - 20000;
          load_regs(ox + $signed($urandom_range(0, 4000)) - 2000,
                    oy + $signed($urandom_range(0, 4000)) - 2000, ox, oy, $urandom);
        end
      endcase
      for (int k = 0; k < NumRandom / 8; k++) begin
        if (ph == 3 && k == 50) long_hold_req = 1'b1;
        if (ph == 5 && k == 100) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        send(pick_request(), res);
      end
    end

    // finish the task, then a few ignored requests
    final_phase = 1'b1;
    rq.avoid_req = 1'b0;
    rq.detx = '0;
    rq.dety = '0;
    for (int k = 0; k < 6; k++) begin
      if (guide.avoid_on) begin
        rq.px = guide.det_x[15:0];
        rq.py = guide.det_y[15:0];
      end else begin
        rq.px = guide.tgt_x[15:0];
        rq.py = guide.tgt_y[15:0];
      end
      rq.avoid_req = k == 5;
      send(rq, res);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    cycles(30);
    if (fail_count == 0) begin
      $display("[axis_priority_waypoint_guidance_unit] OK");
    end else begin
      $display("[axis_priority_waypoint_guidance_unit] ERROR");
    end
    $finish;
  end

endmodule
